[rtl/csrk_pkg.sv]
// Shared types and constants for the comb sort record key block.
// Holds the microcode word format, step addresses and the gap shrink function.
// No dependencies.
package csrk_pkg;

    localparam int YEAR_W  = 14;
    localparam int EXP_W   = 7;
    localparam int TAG_W   = 6;
    localparam int REC_W   = YEAR_W + EXP_W + TAG_W;
    localparam int GAP_W   = 7;
    localparam int SUM_W   = 8;
    localparam int STEP_W  = 4;

    // floor(g * 1000 / 1247) == (g * 52555) >> 16 for every 7-bit g
    localparam int SHRINK_SHIFT = 16;
    localparam int PROD_W       = GAP_W + SHRINK_SHIFT;
    localparam logic [PROD_W-1:0] SHRINK_MUL = PROD_W'(52555);

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        A_LOAD,
        A_INIT_GAP,
        A_PASS_START,
        A_READ_PAIR,
        A_NOP,
        A_WR_LOW,
        A_WR_HIGH,
        A_INC_J,
        A_SHRINK,
        A_EMIT_START,
        A_READ_ONE,
        A_EMIT,
        A_CLEAR
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST_ACC,
        C_GAP_ZERO,
        C_NO_SWAP,
        C_MORE_CMP,
        C_REPEAT,
        C_MORE_OUT
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    localparam step_t S_IDLE       = STEP_W'(0);
    localparam step_t S_INIT_GAP   = STEP_W'(1);
    localparam step_t S_PASS_START = STEP_W'(2);
    localparam step_t S_READ_PAIR  = STEP_W'(3);
    localparam step_t S_COMPARE    = STEP_W'(4);
    localparam step_t S_WR_LOW     = STEP_W'(5);
    localparam step_t S_WR_HIGH    = STEP_W'(6);
    localparam step_t S_ADVANCE    = STEP_W'(7);
    localparam step_t S_PASS_END   = STEP_W'(8);
    localparam step_t S_EMIT_START = STEP_W'(9);
    localparam step_t S_EMIT_READ  = STEP_W'(10);
    localparam step_t S_EMIT       = STEP_W'(11);
    localparam step_t S_FINISH     = STEP_W'(12);

    function automatic logic [GAP_W-1:0] gap_shrink(input logic [GAP_W-1:0] g);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(g) * SHRINK_MUL;
        return prod[SHRINK_SHIFT +: GAP_W];
    endfunction

endpackage

[rtl/comb_sort_record_keys.sv]
// Top level of the comb sort record key block: record store, datapath, sequencer.
// Depends on csrk_pkg and csrk_ucode_rom.
//
// Records load one per cycle while busy is low; a record with last_in set closes
// the set and raises busy. Records past MAX_RECORDS are dropped. The stored set
// is then comb sorted ascending by year, then experience, and streamed out one
// transaction at a time on result_strobe, with last_out on the final one. The
// receiver cannot stall: each result is valid for exactly one cycle. The sort
// time is set by the single-write-port record memory: compares read, compare and
// advance, swaps write each record, passes add start and end steps, and emission
// reads then emits each record. busy drops in the cycle after the last result.
module comb_sort_record_keys #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [csrk_pkg::YEAR_W-1:0]    birth_year,
    input  logic [csrk_pkg::EXP_W-1:0]     experience,
    input  logic [csrk_pkg::TAG_W-1:0]     record_tag,
    input  logic                           last_in,
    output logic                           result_strobe,
    output logic [csrk_pkg::YEAR_W-1:0]    sorted_year,
    output logic [csrk_pkg::EXP_W-1:0]     sorted_experience,
    output logic [csrk_pkg::TAG_W-1:0]     sorted_tag,
    output logic                           last_out
);

    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int REC_W = csrk_pkg::REC_W;
    localparam int SUM_W = csrk_pkg::SUM_W;
    localparam int GAP_W = csrk_pkg::GAP_W;
    localparam int TAG_W = csrk_pkg::TAG_W;
    localparam int EXP_W = csrk_pkg::EXP_W;

    csrk_pkg::uword_t uword;
    csrk_pkg::step_t  upc_reg, upc_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [GAP_W-1:0] gap_reg, gap_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             swap_reg, swap_next;
    logic             strobe_reg, strobe_next;

    logic [REC_W-1:0] mem [MAX_RECORDS];
    logic [REC_W-1:0] lo_reg, hi_reg;
    logic [REC_W-1:0] out_rec_reg;
    logic             last_out_reg;

    logic             accept;
    logic             full;
    logic             key_gt;
    logic             cond_hit;
    logic [SUM_W-1:0] jg_sum;
    logic [SUM_W-1:0] j_inc;
    logic [IDX_W-1:0] jg_addr;
    logic [GAP_W-1:0] gap_shrunk;

    csrk_ucode_rom u_rom (
        .step  (upc_reg),
        .uword (uword)
    );

    assign busy    = (uword.act != csrk_pkg::A_LOAD);
    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(MAX_RECORDS));
    assign key_gt  = lo_reg[REC_W-1:TAG_W] > hi_reg[REC_W-1:TAG_W];
    assign jg_sum  = SUM_W'(j_reg) + SUM_W'(gap_reg);
    assign j_inc   = SUM_W'(j_reg) + SUM_W'(1);
    assign jg_addr = jg_sum[IDX_W-1:0];
    assign gap_shrunk = csrk_pkg::gap_shrink(gap_reg);

    always_comb
    begin
        case (uword.cond)
            csrk_pkg::C_NEVER:        cond_hit = 1'b0;
            csrk_pkg::C_ALWAYS:       cond_hit = 1'b1;
            csrk_pkg::C_NOT_LAST_ACC: cond_hit = !(accept && last_in);
            csrk_pkg::C_GAP_ZERO:     cond_hit = (gap_reg == '0);
            csrk_pkg::C_NO_SWAP:      cond_hit = !key_gt;
            csrk_pkg::C_MORE_CMP:     cond_hit = (jg_sum + SUM_W'(1)) < SUM_W'(count_reg);
            csrk_pkg::C_REPEAT:       cond_hit = (gap_reg != GAP_W'(1)) || swap_reg;
            csrk_pkg::C_MORE_OUT:     cond_hit = j_inc < SUM_W'(count_reg);
            default:                  cond_hit = 1'b0;
        endcase
        upc_next = cond_hit ? uword.target : upc_reg + csrk_pkg::step_t'(1);
    end

    always_comb
    begin
        count_next  = count_reg;
        gap_next    = gap_reg;
        j_next      = j_reg;
        swap_next   = swap_reg;
        strobe_next = 1'b0;
        unique case (uword.act)
            csrk_pkg::A_LOAD:
            begin
                if (accept && !full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            csrk_pkg::A_INIT_GAP:   gap_next = csrk_pkg::gap_shrink(GAP_W'(count_reg));
            csrk_pkg::A_PASS_START:
            begin
                j_next    = '0;
                swap_next = 1'b0;
            end
            csrk_pkg::A_WR_LOW:     swap_next = 1'b1;
            csrk_pkg::A_INC_J:      j_next = j_inc[IDX_W-1:0];
            csrk_pkg::A_SHRINK:
            begin
                if (gap_reg != GAP_W'(1))
                begin
                    gap_next = (gap_shrunk == '0) ? GAP_W'(1) : gap_shrunk;
                end
            end
            csrk_pkg::A_EMIT_START: j_next = '0;
            csrk_pkg::A_EMIT:
            begin
                strobe_next = 1'b1;
                j_next      = j_inc[IDX_W-1:0];
            end
            csrk_pkg::A_CLEAR:
            begin
                count_next = '0;
                gap_next   = '0;
                swap_next  = 1'b0;
            end
            csrk_pkg::A_READ_PAIR, csrk_pkg::A_NOP, csrk_pkg::A_WR_HIGH,
            csrk_pkg::A_READ_ONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg    <= csrk_pkg::S_IDLE;
            count_reg  <= '0;
            gap_reg    <= '0;
            j_reg      <= '0;
            swap_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            upc_reg    <= upc_next;
            count_reg  <= count_next;
            gap_reg    <= gap_next;
            j_reg      <= j_next;
            swap_reg   <= swap_next;
            strobe_reg <= strobe_next;
        end
    end

    // record memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (uword.act == csrk_pkg::A_LOAD && accept && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= {birth_year, experience, record_tag};
        end
        else if (uword.act == csrk_pkg::A_WR_LOW)
        begin
            mem[j_reg] <= hi_reg;
        end
        else if (uword.act == csrk_pkg::A_WR_HIGH)
        begin
            mem[jg_addr] <= lo_reg;
        end

        if (uword.act == csrk_pkg::A_READ_PAIR || uword.act == csrk_pkg::A_READ_ONE)
        begin
            lo_reg <= mem[j_reg];
        end
        if (uword.act == csrk_pkg::A_READ_PAIR)
        begin
            hi_reg <= mem[jg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (uword.act == csrk_pkg::A_EMIT)
        begin
            out_rec_reg  <= lo_reg;
            last_out_reg <= (j_inc == SUM_W'(count_reg));
        end
    end

    assign result_strobe     = strobe_reg;
    assign sorted_year       = out_rec_reg[REC_W-1 -: csrk_pkg::YEAR_W];
    assign sorted_experience = out_rec_reg[TAG_W +: EXP_W];
    assign sorted_tag        = out_rec_reg[TAG_W-1:0];
    assign last_out          = last_out_reg;

endmodule

[rtl/csrk_ucode_rom.sv]
// Microcode program store for the comb sort sequencer.
// One control word per step: datapath action, jump condition, jump target.
// Depends on csrk_pkg.
module csrk_ucode_rom (
    input  csrk_pkg::step_t  step,
    output csrk_pkg::uword_t uword
);

    always_comb
    begin
        unique case (step)
            csrk_pkg::S_IDLE:
                uword = '{csrk_pkg::A_LOAD, csrk_pkg::C_NOT_LAST_ACC, csrk_pkg::S_IDLE};
            csrk_pkg::S_INIT_GAP:
                uword = '{csrk_pkg::A_INIT_GAP, csrk_pkg::C_NEVER, csrk_pkg::S_IDLE};
            csrk_pkg::S_PASS_START:
                uword = '{csrk_pkg::A_PASS_START, csrk_pkg::C_GAP_ZERO,
                          csrk_pkg::S_EMIT_START};
            csrk_pkg::S_READ_PAIR:
                uword = '{csrk_pkg::A_READ_PAIR, csrk_pkg::C_NEVER, csrk_pkg::S_IDLE};
            csrk_pkg::S_COMPARE:
                uword = '{csrk_pkg::A_NOP, csrk_pkg::C_NO_SWAP, csrk_pkg::S_ADVANCE};
            csrk_pkg::S_WR_LOW:
                uword = '{csrk_pkg::A_WR_LOW, csrk_pkg::C_NEVER, csrk_pkg::S_IDLE};
            csrk_pkg::S_WR_HIGH:
                uword = '{csrk_pkg::A_WR_HIGH, csrk_pkg::C_NEVER, csrk_pkg::S_IDLE};
            csrk_pkg::S_ADVANCE:
                uword = '{csrk_pkg::A_INC_J, csrk_pkg::C_MORE_CMP, csrk_pkg::S_READ_PAIR};
            csrk_pkg::S_PASS_END:
                uword = '{csrk_pkg::A_SHRINK, csrk_pkg::C_REPEAT, csrk_pkg::S_PASS_START};
            csrk_pkg::S_EMIT_START:
                uword = '{csrk_pkg::A_EMIT_START, csrk_pkg::C_NEVER, csrk_pkg::S_IDLE};
            csrk_pkg::S_EMIT_READ:
                uword = '{csrk_pkg::A_READ_ONE, csrk_pkg::C_NEVER, csrk_pkg::S_IDLE};
            csrk_pkg::S_EMIT:
                uword = '{csrk_pkg::A_EMIT, csrk_pkg::C_MORE_OUT, csrk_pkg::S_EMIT_READ};
            csrk_pkg::S_FINISH:
                uword = '{csrk_pkg::A_CLEAR, csrk_pkg::C_ALWAYS, csrk_pkg::S_IDLE};
            default:
                uword = '{csrk_pkg::A_CLEAR, csrk_pkg::C_ALWAYS, csrk_pkg::S_IDLE};
        endcase
    end

endmodule

[rtl/csrk_checker.sv]
// Port-level checker for comb_sort_record_keys, attached by bind.
// Depends only on the top-level ports.
module csrk_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_in,
    input logic result_strobe,
    input logic last_out
);

    a_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result transaction while not busy");

    a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result transactions closer than two cycles");

    a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_out) |-> busy ##1 (!busy && !result_strobe))
        else $error("block not idle after final result");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_in) |=> !busy)
        else $error("busy after a non-final record");

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_in) |=> busy)
        else $error("final record did not start the sort");

endmodule

bind comb_sort_record_keys csrk_checker u_csrk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .last_in       (last_in),
    .result_strobe (result_strobe),
    .last_out      (last_out)
);

[test/csrk_checker.sv]
// Checker for comb_sort_record_keys: predicts the sorted record stream and compares it.
// Watches the record load channel and the result strobe channel only.
// Depends on csrk_pkg for field widths.
`timescale 1ns / 100ps

module csrk_tb_checker #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [csrk_pkg::YEAR_W-1:0]    birth_year,
    input  logic [csrk_pkg::EXP_W-1:0]     experience,
    input  logic [csrk_pkg::TAG_W-1:0]     record_tag,
    input  logic                           last_in,
    input  logic                           result_strobe,
    input  logic [csrk_pkg::YEAR_W-1:0]    sorted_year,
    input  logic [csrk_pkg::EXP_W-1:0]     sorted_experience,
    input  logic [csrk_pkg::TAG_W-1:0]     sorted_tag,
    input  logic                           last_out,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic [csrk_pkg::YEAR_W-1:0] year;
        logic [csrk_pkg::EXP_W-1:0]  exp;
        logic [csrk_pkg::TAG_W-1:0]  tag;
    } record_t;

    typedef struct packed {
        record_t rec;
        logic    last;
    } sorted_rec_t;

    record_t     held_records [MAX_RECORDS];
    int          held_count;
    sorted_rec_t sorted_q [$];

    function automatic int shrink_gap(input int g);
        return (g * 1000) / 1247;
    endfunction

    task automatic comb_sort_held();
        int          n;
        int          gap;
        int          j;
        bit          swapped;
        record_t     tmp;
        sorted_rec_t item;
        n = held_count;
        gap = shrink_gap(n);
        while (gap >= 1)
        begin
            swapped = 1'b0;
            for (j = 0; j + gap < n; j++)
            begin
                if ({held_records[j].year, held_records[j].exp} >
                    {held_records[j+gap].year, held_records[j+gap].exp})
                begin
                    tmp = held_records[j];
                    held_records[j] = held_records[j+gap];
                    held_records[j+gap] = tmp;
                    swapped = 1'b1;
                end
            end
            if (gap == 1)
            begin
                if (!swapped)
                    break;
            end
            else
            begin
                gap = shrink_gap(gap);
                if (gap < 1)
                    gap = 1;
            end
        end
        for (j = 0; j < n; j++)
        begin
            item.rec = held_records[j];
            item.last = (j == n - 1);
            sorted_q.insert(sorted_q.size(), item);
        end
        held_count = 0;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sorted_rec_t want;
        if (!rst_n)
        begin
            held_count = 0;
            sorted_q.delete();
            pending = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (sorted_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
                             $time, sorted_year, sorted_experience, sorted_tag, last_out);
                    fail_count++;
                end
                else
                begin
                    want = sorted_q.pop_front();
                    check_field("sorted_year", want.rec.year, sorted_year);
                    check_field("sorted_experience", want.rec.exp, sorted_experience);
                    check_field("sorted_tag", want.rec.tag, sorted_tag);
                    check_field("last_out", want.last, last_out);
                end
            end
            if (start && !busy)
            begin
                if (held_count < MAX_RECORDS)
                begin
                    held_records[held_count] = '{birth_year, experience, record_tag};
                    held_count++;
                end
                if (last_in)
                    comb_sort_held();
            end
            pending = sorted_q.size();
        end
    end

endmodule

[test/tb_comb_sort_record_keys.sv]
// Testbench top for comb_sort_record_keys: clock, reset, record stimulus and verdict.
// Depends on csrk_pkg, the block under test and csrk_tb_checker.
`timescale 1ns / 100ps

module tb_comb_sort_record_keys;

    localparam int MAX_RECORDS     = 64;
    localparam int STALL_LIMIT     = 100000;
    localparam int ITEMS_PER_PHASE = 125;

    typedef enum int {
        KEYS_SPREAD,
        KEYS_CLUSTERED,
        KEYS_RAW
    } key_mix_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [csrk_pkg::YEAR_W-1:0] birth_year = '0;
    logic [csrk_pkg::EXP_W-1:0]  experience = '0;
    logic [csrk_pkg::TAG_W-1:0]  record_tag = '0;
    logic                        last_in = 1'b0;
    logic                        result_strobe;
    logic [csrk_pkg::YEAR_W-1:0] sorted_year;
    logic [csrk_pkg::EXP_W-1:0]  sorted_experience;
    logic [csrk_pkg::TAG_W-1:0]  sorted_tag;
    logic                        last_out;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    comb_sort_record_keys #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .birth_year(birth_year),
        .experience(experience),
        .record_tag(record_tag),
        .last_in(last_in),
        .result_strobe(result_strobe),
        .sorted_year(sorted_year),
        .sorted_experience(sorted_experience),
        .sorted_tag(sorted_tag),
        .last_out(last_out)
    );

    csrk_tb_checker #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .birth_year(birth_year),
        .experience(experience),
        .record_tag(record_tag),
        .last_in(last_in),
        .result_strobe(result_strobe),
        .sorted_year(sorted_year),
        .sorted_experience(sorted_experience),
        .sorted_tag(sorted_tag),
        .last_out(last_out),
        .fail_count(fail_count),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_comb_sort_record_keys: FAIL");
            $finish;
        end
    end

    task automatic send_record(input logic [csrk_pkg::YEAR_W-1:0] year,
                               input logic [csrk_pkg::EXP_W-1:0] exp,
                               input logic [csrk_pkg::TAG_W-1:0] tag, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        birth_year <= year;
        experience <= exp;
        record_tag <= tag;
        last_in <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_set(input int n, input key_mix_t mix);
        int                          i;
        logic [csrk_pkg::YEAR_W-1:0] year;
        logic [csrk_pkg::EXP_W-1:0]  exp;
        for (i = 0; i < n; i++)
        begin
            case (mix)
                KEYS_SPREAD:
                begin
                    year = csrk_pkg::YEAR_W'($urandom_range(9999));
                    exp = csrk_pkg::EXP_W'($urandom_range(127));
                end
                KEYS_CLUSTERED:
                begin
                    year = csrk_pkg::YEAR_W'(1990 + $urandom_range(3));
                    exp = csrk_pkg::EXP_W'($urandom_range(3));
                end
                default:
                begin
                    year = csrk_pkg::YEAR_W'($urandom);
                    exp = csrk_pkg::EXP_W'($urandom);
                end
            endcase
            send_record(year, exp, csrk_pkg::TAG_W'($urandom), i == n - 1);
        end
    endtask

    // hold off until the block has emitted everything and dropped busy
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int       phase_idle [4];
        int       phase;
        int       target;
        int       set_idx;
        int       n;
        int       pick;
        key_mix_t mix;
        phase_idle = '{0, 76, 0, 21};
        set_idx = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single record, out-of-range year
        send_record(14'h3FFF, 7'h7F, 6'h3F, 1'b1);
        // two records that must swap
        send_record(14'd9999, 7'h7F, 6'h3F, 1'b0);
        send_record(14'd0, 7'd0, 6'd0, 1'b1);
        // equal keys
        send_record(14'd2000, 7'd10, 6'd1, 1'b0);
        send_record(14'd2000, 7'd10, 6'd2, 1'b0);
        send_record(14'd2000, 7'd10, 6'd3, 1'b0);
        send_record(14'd2000, 7'd10, 6'd4, 1'b1);
        // year extremes, experience as tie breaker
        send_record(14'h3FFF, 7'd0, 6'd5, 1'b0);
        send_record(14'd9999, 7'h7F, 6'd6, 1'b0);
        send_record(14'd9999, 7'd0, 6'd7, 1'b0);
        send_record(14'd0, 7'h7F, 6'd8, 1'b0);
        send_record(14'h3FFF, 7'h7F, 6'd9, 1'b0);
        send_record(14'd1, 7'd1, 6'd10, 1'b0);
        send_record(14'd0, 7'd0, 6'h3F, 1'b1);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = phase_idle[phase];
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                // store overflow with last on a dropped record, then an exactly full store
                if (set_idx == 2)
                    n = MAX_RECORDS + 2;
                else if (set_idx == 5)
                    n = MAX_RECORDS;
                else if ($urandom_range(19) == 0)
                    n = $urandom_range(MAX_RECORDS + 4, 16);
                else
                    n = $urandom_range(10, 1);
                pick = $urandom_range(9);
                if (pick < 6)
                    mix = KEYS_SPREAD;
                else if (pick < 8)
                    mix = KEYS_CLUSTERED;
                else
                    mix = KEYS_RAW;
                send_set(n, mix);
                set_idx++;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_comb_sort_record_keys: PASS");
        else
            $display("tb_comb_sort_record_keys: FAIL");
        $finish;
    end

endmodule
